// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the blender RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define CAB_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled while reset is held
`define CAB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== rtl/core/cab_pkg.sv =====
// ----------------------------------------------------------------------------
// cab_pkg
// Types, codes and small arithmetic helpers for the coverage alpha blender
// ----------------------------------------------------------------------------
`default_nettype none

package cab_pkg;

    // item commands; the unused code behaves as a read
    localparam logic [1:0] CMD_BLEND = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_GLYPH_COLOR = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_X    = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_Y    = 2'd2;
    localparam logic [1:0] CFG_FRAME_WIDTH = 2'd3;

    localparam int CFG_DATA_W  = 32;
    localparam int FW_W        = 9;
    localparam int COORD_W     = 9;
    localparam logic [8:0] FRAME_WIDTH_RESET = 9'd256;

    // one stored pixel, blue in the low byte
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // operands of one blend
    typedef struct packed {
        logic [7:0] k;
        pixel_t     color;
        pixel_t     old;
    } mix_req_t;

    // floor(x / 255), exact for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] tmp;
        tmp = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return tmp[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cab_mix.sv =====
// ----------------------------------------------------------------------------
// cab_mix
// Per-channel blend of glyph colour over the stored pixel with weight k
// ----------------------------------------------------------------------------
`default_nettype none

module cab_mix (
    input  cab_pkg::mix_req_t req,
    output cab_pkg::pixel_t   mixed
);
    import cab_pkg::*;

    // (k*c + (255-k)*old) rewritten as old*255 + k*(c-old): one multiplier a lane
    function automatic logic [7:0] mix_lane(input logic [7:0] k, input logic [7:0] c,
                                            input logic [7:0] old);
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        logic signed [17:0] base;
        logic signed [17:0] sum;
        diff = $signed({1'b0, c}) - $signed({1'b0, old});
        prod = 18'($signed({1'b0, k})) * 18'(diff);
        base = $signed({2'b00, old, 8'd0}) - $signed({10'd0, old});
        sum  = base + prod;
        return div255(sum[15:0]);
    endfunction

    // three independent channel lanes
    always_comb begin
        mixed.red   = mix_lane(req.k, req.color.red,   req.old.red);
        mixed.green = mix_lane(req.k, req.color.green, req.old.green);
        mixed.blue  = mix_lane(req.k, req.color.blue,  req.old.blue);
    end

endmodule

`default_nettype wire

// ===== rtl/core/coverage_alpha_blender.sv =====
// ----------------------------------------------------------------------------
// coverage_alpha_blender
// RGB888 frame store with per-pixel blending of a one-colour coverage mask
// ----------------------------------------------------------------------------
// Usage: each input item carries a command in s_tuser (blend, read, clear)
// and a glyph-relative x, y and coverage byte in s_tdata. The glyph origin is
// added to form the frame column and row, and the pixel at row*width+column
// is read, updated and written back. Every item gives one result item on the
// m_ side: the pixel's channels after the operation in m_tdata, and in
// m_tuser a flag for addresses outside the frame (channels zero, no write).
// Pipeline: an accepted item passes the address stage, the memory read stage
// and the output register. Throughput: one item per cycle unless the receiver
// stalls, set by the single read-modify-write pass through the frame memory;
// back-to-back accesses to the same pixel are forwarded from the write stage,
// so there is no interlock bubble. Reset clears the pipeline valids and
// returns the configuration registers to their reset values; the frame memory
// is not cleared, so pixels must be cleared or written first. When the
// receiver stalls, results stay in the output register and the pipeline keeps
// accepting until its two inner stages are full as well. The user writes
// configuration via cfg_we/cfg_index/cfg_wdata only while idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module coverage_alpha_blender #(
    parameter int MAX_FRAME_WIDTH  = 256,
    parameter int MAX_FRAME_HEIGHT = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [cab_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // glyph_x[7:0], glyph_y[15:8], coverage[23:16]
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // blue_out[7:0], green_out[15:8], red_out[23:16]
    output logic             m_tuser    // outside_frame[0]
);
    import cab_pkg::*;

    localparam int DEPTH  = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LIN_W  = (ADDR_W > COORD_W + FW_W + 1) ? ADDR_W : COORD_W + FW_W + 1;
    localparam int CMP_W  = 14;

    // configuration registers
    logic [31:0]     glyph_color_reg;
    logic [7:0]      origin_x_reg;
    logic [7:0]      origin_y_reg;
    logic [FW_W-1:0] frame_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_color_reg <= '0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            frame_width_reg <= FRAME_WIDTH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GLYPH_COLOR: glyph_color_reg <= cfg_wdata;
                CFG_ORIGIN_X:    origin_x_reg    <= cfg_wdata[7:0];
                CFG_ORIGIN_Y:    origin_y_reg    <= cfg_wdata[7:0];
                CFG_FRAME_WIDTH: frame_width_reg <= cfg_wdata[FW_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic s1_valid_reg, s2_valid_reg;
    logic out_en, s2_fire, s2_load, s1_load;

    assign out_en   = !m_tvalid || m_tready;
    assign s2_fire  = s2_valid_reg && out_en;
    assign s2_load  = !s2_valid_reg || s2_fire;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign s_tready = s1_load;

    // address and weight computed on accept
    logic [FW_W-1:0]    fw_eff;
    logic [COORD_W-1:0] col, row;
    logic               outside_next;
    logic [LIN_W-1:0]   lin_addr;
    logic [15:0]        k_prod;

    always_comb begin
        fw_eff = (CMP_W'(frame_width_reg) > CMP_W'(MAX_FRAME_WIDTH))
               ? FW_W'(MAX_FRAME_WIDTH) : frame_width_reg;
        col = {1'b0, origin_x_reg} + {1'b0, s_tdata[7:0]};
        row = {1'b0, origin_y_reg} + {1'b0, s_tdata[15:8]};
        outside_next = (col >= fw_eff) || (CMP_W'(row) >= CMP_W'(MAX_FRAME_HEIGHT));
        lin_addr = LIN_W'(row) * LIN_W'(fw_eff) + LIN_W'(col);
        k_prod = {8'd0, s_tdata[23:16]} * {8'd0, 8'd255 - glyph_color_reg[7:0]};
    end

    // stage 1: address, command and weight
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [1:0]        s1_cmd_reg;
    logic              s1_outside_reg;
    logic [7:0]        s1_k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_load) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load && s_tvalid) begin
            s1_addr_reg    <= lin_addr[ADDR_W-1:0];
            s1_cmd_reg     <= s_tuser;
            s1_outside_reg <= outside_next;
            s1_k_reg       <= div255(k_prod);
        end
    end

    // stage 2 control and forwarding
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [1:0]        s2_cmd_reg;
    logic              s2_outside_reg;
    logic [7:0]        s2_k_reg;
    logic              fwd_reg;
    pixel_t            fwd_pix_reg;
    pixel_t            rd_pix_reg;
    logic              rd_en, mem_we;
    pixel_t            new_pix;

    assign rd_en  = s1_valid_reg && s2_load;
    assign mem_we = s2_fire && !s2_outside_reg &&
                    (s2_cmd_reg == CMD_BLEND || s2_cmd_reg == CMD_CLEAR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_load) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            s2_addr_reg    <= s1_addr_reg;
            s2_cmd_reg     <= s1_cmd_reg;
            s2_outside_reg <= s1_outside_reg;
            s2_k_reg       <= s1_k_reg;
            fwd_reg        <= mem_we && (s2_addr_reg == s1_addr_reg);
            fwd_pix_reg    <= new_pix;
        end
    end

    // frame memory, one read and one write port
    pixel_t frame_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_pix_reg <= frame_mem[s1_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[s2_addr_reg] <= new_pix;
        end
    end

    // blend of the current pixel
    mix_req_t mix_req;
    pixel_t   old_pix, mixed_pix;

    assign old_pix       = fwd_reg ? fwd_pix_reg : rd_pix_reg;
    assign mix_req.k     = s2_k_reg;
    assign mix_req.color = glyph_color_reg[31:8];
    assign mix_req.old   = old_pix;

    cab_mix u_mix (
        .req   (mix_req),
        .mixed (mixed_pix)
    );

    always_comb begin
        case (s2_cmd_reg)
            CMD_BLEND: new_pix = mixed_pix;
            CMD_CLEAR: new_pix = '0;
            default:   new_pix = old_pix;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_en) begin
            m_tvalid <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_fire) begin
            m_tdata <= s2_outside_reg ? 24'd0 : new_pix;
            m_tuser <= s2_outside_reg;
        end
    end

    // checks
`include "assert_macros.svh"

    `CAB_ASSERT_IMPL(a_we_in_frame, aclk, aresetn, mem_we, s2_valid_reg && !s2_outside_reg)
    `CAB_ASSERT_NEXT(a_s2_holds, aclk, aresetn, s2_valid_reg && !out_en, s2_valid_reg)
    `CAB_ASSERT_NEXT(a_fwd_set, aclk, aresetn,
                     rd_en && mem_we && s1_addr_reg == s2_addr_reg, fwd_reg)
    `CAB_ASSERT_IMPL(a_outside_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == 24'd0)
    `CAB_ASSERT_NEXT(a_fill_out, aclk, aresetn, s2_fire, m_tvalid)

endmodule

`default_nettype wire

// ===== tb/coverage_alpha_blender_tb.sv =====
// ----------------------------------------------------------------------------
// coverage_alpha_blender_tb
// Self-checking bench for the coverage mask blender and its frame store
// ----------------------------------------------------------------------------
// A directed table covers the corner cases first: reset state, full and zero
// coverage, opaque and fully transparent colour, the spare command, and
// addresses past the frame edge and row limit. Zero, unit and oversized
// frame widths are also covered. Random phases follow, each under a fresh
// register setting. Most items stay in a small pixel window, so that
// repeated and back-to-back accesses to one pixel are common. The bench
// keeps its own frame image and register copy, and predicts each result from
// them unless a directed row gives it literally. Pixels are cleared before
// they are first read or blended. Results are compared field by field, in
// order, with random stalls on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------

module coverage_alpha_blender_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cab_pkg::*;

    localparam int FRAME_MAX_W = 256;
    localparam int FRAME_MAX_H = 256;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 140;
    localparam int HOLD_CYCLES = 60;

    // the fourth command code is unused and behaves as a read
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // expected result of one item
    typedef struct packed {
        pixel_t pix;
        logic   outside;
    } result_t;

    // one row of the directed table: a register write or an item
    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        logic [1:0]  cmd;
        logic [7:0]  gx;
        logic [7:0]  gy;
        logic [7:0]  cov;
        bit          use_lit;
        result_t     lit;
    } step_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    // bench copy of the registers and the frame image
    logic [31:0] mdl_color;
    logic [7:0]  mdl_ox;
    logic [7:0]  mdl_oy;
    logic [8:0]  mdl_fw;
    pixel_t      frame_model [0:FRAME_MAX_W*FRAME_MAX_H-1];
    bit          pixel_valid [0:FRAME_MAX_W*FRAME_MAX_H-1];

    result_t     expected_pixels [$];
    step_row_t   directed [$];
    int          errors = 0;
    bit          idle_on = 1'b1;
    int          hold_requested = 0;
    int          hold_served = 0;
    int          stall_left = 0;

    coverage_alpha_blender #(
        .MAX_FRAME_WIDTH  (FRAME_MAX_W),
        .MAX_FRAME_HEIGHT (FRAME_MAX_H)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // glyph_x[7:0], glyph_y[15:8], coverage[23:16]
        .s_tuser   (s_tuser),   // command[1:0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // blue_out[7:0], green_out[15:8], red_out[23:16]
        .m_tuser   (m_tuser)    // outside_frame[0]
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("FAIL coverage_alpha_blender");
        $finish;
    end

    // frame address of a glyph pixel; returns 1 when it lies inside the frame
    function automatic bit locate(input logic [7:0] gx, input logic [7:0] gy,
                                  output int unsigned addr);
        int unsigned col;
        int unsigned row;
        int unsigned fw;
        col  = int'(mdl_ox) + int'(gx);
        row  = int'(mdl_oy) + int'(gy);
        fw   = (int'(mdl_fw) > FRAME_MAX_W) ? FRAME_MAX_W : int'(mdl_fw);
        addr = row * fw + col;
        return (col < fw) && (row < FRAME_MAX_H);
    endfunction

    // weighted mix of glyph colour and old channel, truncating
    function automatic logic [7:0] mix_channel(int unsigned k, logic [7:0] c,
                                               logic [7:0] old);
        int unsigned sum;
        sum = k * int'(c) + (255 - k) * int'(old);
        return 8'(sum / 255);
    endfunction

    // apply one item to the frame image and return the pixel afterwards
    function automatic result_t apply_pixel_op(logic [1:0] cmd, logic [7:0] gx,
                                               logic [7:0] gy, logic [7:0] cov);
        result_t     res;
        int unsigned addr;
        int unsigned k;
        pixel_t      pix;
        res = '0;
        if (!locate(gx, gy, addr)) begin
            res.outside = 1'b1;
            return res;
        end
        pix = frame_model[addr];
        case (cmd)
            CMD_BLEND: begin
                k = int'(cov) * (255 - int'(mdl_color[7:0])) / 255;
                pix.blue  = mix_channel(k, mdl_color[15:8], pix.blue);
                pix.green = mix_channel(k, mdl_color[23:16], pix.green);
                pix.red   = mix_channel(k, mdl_color[31:24], pix.red);
                frame_model[addr] = pix;
                pixel_valid[addr] = 1'b1;
            end
            CMD_CLEAR: begin
                pix = '0;
                frame_model[addr] = pix;
                pixel_valid[addr] = 1'b1;
            end
            default: ;
        endcase
        res.pix = pix;
        return res;
    endfunction

    function automatic step_row_t item_row(logic [1:0] cmd, logic [7:0] gx,
                                           logic [7:0] gy, logic [7:0] cov);
        step_row_t r;
        r.is_cfg  = 1'b0;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.cmd     = cmd;
        r.gx      = gx;
        r.gy      = gy;
        r.cov     = cov;
        r.use_lit = 1'b0;
        r.lit     = '0;
        return r;
    endfunction

    function automatic step_row_t lit_row(logic [1:0] cmd, logic [7:0] gx,
                                          logic [7:0] gy, logic [7:0] cov,
                                          logic [23:0] pix, logic outside);
        step_row_t r;
        r = item_row(cmd, gx, gy, cov);
        r.use_lit = 1'b1;
        r.lit.pix = pix;
        r.lit.outside = outside;
        return r;
    endfunction

    function automatic step_row_t cfg_row(logic [1:0] idx, logic [31:0] val);
        step_row_t r;
        r = item_row(CMD_READ, '0, '0, '0);
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic void flag_mismatch(string field, logic [7:0] want_v,
                                          logic [7:0] got_v);
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
    endfunction

    // offer one item, wait for acceptance and record its expected result
    task automatic send_item(logic [1:0] cmd, logic [7:0] gx, logic [7:0] gy,
                             logic [7:0] cov, bit use_lit, result_t lit);
        result_t res;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {cov, gy, gx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = apply_pixel_op(cmd, gx, gy, cov);
        expected_pixels.push_back(use_lit ? lit : res);
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_GLYPH_COLOR: mdl_color = val;
            CFG_ORIGIN_X:    mdl_ox    = val[7:0];
            CFG_ORIGIN_Y:    mdl_oy    = val[7:0];
            CFG_FRAME_WIDTH: mdl_fw    = val[8:0];
            default: ;
        endcase
    endtask

    // result checking against the oldest expectation
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item, expected none, got %h/%b",
                         $time, m_tdata, m_tuser);
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata[7:0] !== want.pix.blue)
                    flag_mismatch("blue_out", want.pix.blue, m_tdata[7:0]);
                if (m_tdata[15:8] !== want.pix.green)
                    flag_mismatch("green_out", want.pix.green, m_tdata[15:8]);
                if (m_tdata[23:16] !== want.pix.red)
                    flag_mismatch("red_out", want.pix.red, m_tdata[23:16]);
                if (m_tuser !== want.outside)
                    flag_mismatch("outside_frame", 8'(want.outside), 8'(m_tuser));
            end
        end
    end

    // receiver readiness: random stall bursts and the requested long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_requested != hold_served) begin
            hold_served = hold_requested;
            stall_left  = HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        step_row_t   row;
        logic [1:0]  cmd;
        logic [7:0]  gx;
        logic [7:0]  gy;
        logic [7:0]  cov;
        logic [31:0] color;
        logic [8:0]  fw;
        logic [7:0]  ox;
        logic [7:0]  oy;
        int unsigned addr;
        int unsigned pick;

        mdl_color = '0;
        mdl_ox    = '0;
        mdl_oy    = '0;
        mdl_fw    = FRAME_WIDTH_RESET;
        gx = '0;
        gy = '0;

        // directed table, starting from the reset register values
        directed.push_back(lit_row(CMD_CLEAR, 8'd0, 8'd0, 8'h55, 24'h000000, 1'b0));
        directed.push_back(lit_row(CMD_READ,  8'd0, 8'd0, 8'h00, 24'h000000, 1'b0));
        directed.push_back(lit_row(CMD_SPARE, 8'd0, 8'd0, 8'hAA, 24'h000000, 1'b0));
        directed.push_back(lit_row(CMD_BLEND, 8'd0, 8'd0, 8'hFF, 24'h000000, 1'b0));
        directed.push_back(lit_row(CMD_CLEAR, 8'd255, 8'd255, 8'h00, 24'h000000, 1'b0));
        // opaque colour at full and zero coverage
        directed.push_back(cfg_row(CFG_GLYPH_COLOR, 32'hFF804000));
        directed.push_back(lit_row(CMD_BLEND, 8'd0, 8'd0, 8'hFF, 24'hFF8040, 1'b0));
        directed.push_back(lit_row(CMD_READ,  8'd0, 8'd0, 8'h00, 24'hFF8040, 1'b0));
        directed.push_back(lit_row(CMD_BLEND, 8'd0, 8'd0, 8'h00, 24'hFF8040, 1'b0));
        directed.push_back(lit_row(CMD_CLEAR, 8'd0, 8'd0, 8'hFF, 24'h000000, 1'b0));
        // back-to-back blends of the far corner pixel
        directed.push_back(item_row(CMD_BLEND, 8'd255, 8'd255, 8'd128));
        directed.push_back(item_row(CMD_BLEND, 8'd255, 8'd255, 8'd200));
        directed.push_back(item_row(CMD_SPARE, 8'd255, 8'd255, 8'd0));
        // fully transparent colour leaves the pixel alone
        directed.push_back(cfg_row(CFG_GLYPH_COLOR, 32'hFFFFFFFF));
        directed.push_back(item_row(CMD_BLEND, 8'd255, 8'd255, 8'hFF));
        // column past the frame edge, then row past the last row
        directed.push_back(cfg_row(CFG_ORIGIN_X, 32'd255));
        directed.push_back(lit_row(CMD_BLEND, 8'd1, 8'd0, 8'hFF, 24'h000000, 1'b1));
        directed.push_back(lit_row(CMD_CLEAR, 8'd0, 8'd0, 8'h00, 24'h000000, 1'b0));
        directed.push_back(item_row(CMD_BLEND, 8'd0, 8'd0, 8'd77));
        directed.push_back(cfg_row(CFG_ORIGIN_Y, 32'd255));
        directed.push_back(lit_row(CMD_READ, 8'd0, 8'd1, 8'h00, 24'h000000, 1'b1));
        directed.push_back(item_row(CMD_READ, 8'd0, 8'd0, 8'h00));
        directed.push_back(lit_row(CMD_READ, 8'd255, 8'd255, 8'h00, 24'h000000, 1'b1));
        // zero width puts everything outside
        directed.push_back(cfg_row(CFG_FRAME_WIDTH, 32'd0));
        directed.push_back(lit_row(CMD_READ, 8'd0, 8'd0, 8'h00, 24'h000000, 1'b1));
        // oversized width saturates to the full row
        directed.push_back(cfg_row(CFG_ORIGIN_X, 32'd0));
        directed.push_back(cfg_row(CFG_ORIGIN_Y, 32'd0));
        directed.push_back(cfg_row(CFG_FRAME_WIDTH, 32'd511));
        directed.push_back(item_row(CMD_READ, 8'd255, 8'd255, 8'h00));
        // single-column frame
        directed.push_back(cfg_row(CFG_FRAME_WIDTH, 32'd1));
        directed.push_back(lit_row(CMD_CLEAR, 8'd0, 8'd5, 8'h00, 24'h000000, 1'b0));
        directed.push_back(lit_row(CMD_READ,  8'd1, 8'd0, 8'h00, 24'h000000, 1'b1));
        directed.push_back(cfg_row(CFG_GLYPH_COLOR, 32'h12345678));
        directed.push_back(item_row(CMD_BLEND, 8'd0, 8'd5, 8'hFF));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            row = directed[i];
            if (row.is_cfg) begin
                drain_results();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_item(row.cmd, row.gx, row.gy, row.cov, row.use_lit, row.lit);
            end
        end

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            color = $urandom;
            ox    = 8'($urandom_range(0, 15));
            oy    = 8'($urandom_range(0, 15));
            case (p)
                0: fw = 9'd256;
                1: begin fw = 9'd511; color[7:0] = 8'h00; end
                2: begin fw = 9'($urandom_range(1, 256)); color[7:0] = 8'hFF; end
                3: begin fw = 9'd16; color = 32'hFFFFFF00; end
                4: begin fw = 9'd256; ox = 8'd240; oy = 8'd240; end
                default: fw = 9'($urandom_range(257, 511));
            endcase
            write_reg(CFG_GLYPH_COLOR, color);
            write_reg(CFG_ORIGIN_X, 32'(ox));
            write_reg(CFG_ORIGIN_Y, 32'(oy));
            write_reg(CFG_FRAME_WIDTH, 32'(fw));
            if (p == PHASES - 1)
                idle_on <= 1'b0;

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // long receiver hold-off while items keep coming
                if (p == 2 && i == 30)
                    hold_requested <= hold_requested + 1;
                if ($urandom_range(0, 99) < 85) begin
                    // small window, often the same pixel again
                    if ($urandom_range(0, 3) != 0) begin
                        gx = 8'($urandom_range(0, 7));
                        gy = 8'($urandom_range(0, 7));
                    end
                    pick = $urandom_range(0, 9);
                    cmd  = (pick < 6) ? CMD_BLEND : (pick < 8) ? CMD_READ :
                           (pick < 9) ? CMD_CLEAR : CMD_SPARE;
                end else begin
                    gx  = 8'($urandom);
                    gy  = 8'($urandom);
                    cmd = 2'($urandom_range(0, 3));
                end
                cov = 8'($urandom);
                // a pixel is cleared before it is first read or blended
                if (cmd != CMD_CLEAR && locate(gx, gy, addr) && !pixel_valid[addr])
                    cmd = CMD_CLEAR;
                send_item(cmd, gx, gy, cov, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS coverage_alpha_blender");
        end else begin
            $display("FAIL coverage_alpha_blender");
        end
        $finish;
    end

endmodule
